/* hdl/smbus_byte_data_sequencer_unit_defines.svh */
// Assertion macros used by the byte-data sequencer back end.
`ifndef SMBUS_BYTE_DATA_SEQUENCER_UNIT_DEFINES_SVH
`define SMBUS_BYTE_DATA_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SBDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/sbds_pkg.sv */
// Shared types and constants of the SMBus byte-data sequencer.
package sbds_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int TICK_W = 20;
	localparam int CFG_INDEX_W = 1;
	localparam int STEP_W = 3;

	localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RESET = 20'd100000;
	localparam logic [TICK_W-1:0] CYCLE_TIMEOUT_RESET = 20'd50000;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CYCLE_TIMEOUT = 1'd1;

	localparam logic [2:0] CMD_START_READ = 3'd0;
	localparam logic [2:0] CMD_START_WRITE = 3'd1;
	localparam logic [2:0] CMD_STATUS = 3'd2;
	localparam logic [2:0] CMD_DATA = 3'd3;
	localparam logic [2:0] CMD_TICK = 3'd4;

	localparam logic [1:0] KIND_RD = 2'd0;
	localparam logic [1:0] KIND_WR = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [3:0] OFF_STATUS = 4'd0;
	localparam logic [3:0] OFF_ENABLE = 4'd2;
	localparam logic [3:0] OFF_ADDRESS = 4'd4;
	localparam logic [3:0] OFF_DATA = 4'd6;
	localparam logic [3:0] OFF_COMMAND = 4'd8;

	localparam logic [2:0] ERR_OK = 3'd0;
	localparam logic [2:0] ERR_BUSY = 3'd1;
	localparam logic [2:0] ERR_IO = 3'd2;
	localparam logic [2:0] ERR_CANCEL = 3'd3;
	localparam logic [2:0] ERR_TIME = 3'd4;

	localparam int ST_ABORT_BIT = 0;
	localparam int ST_COLLIDE_BIT = 1;
	localparam int ST_PROTO_BIT = 2;
	localparam int ST_BUSY_BIT = 3;
	localparam int ST_DONE_BIT = 4;
	localparam int ST_BUSTO_BIT = 5;

	localparam logic [7:0] ST_CLEAR_ALL = 8'h3F;
	localparam logic [7:0] KICK_BYTE_DATA_START = 8'h0A;

	typedef enum logic [2:0] {
		JOB_RD_STATUS,
		JOB_RD_DATA,
		JOB_DONE,
		JOB_PROGRAM,
		JOB_CLEAR_DONE,
		JOB_CLEAR2_DONE
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [2:0] err;
		logic [7:0] rb;
		logic [7:0] addr_byte;
		logic [7:0] command;
		logic [7:0] data;
		logic       is_read;
	} job_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] offset;
		logic [7:0] data;
		logic [2:0] err;
		logic [7:0] rb;
		logic       last;
	} result_t;

endpackage

/* hdl/sbds_front.sv */
// Front end: accepts items, tracks the transaction phase and classifies each item into a job.
module sbds_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [2:0]                   cmd,
	input  logic [6:0]                   target_address,
	input  logic [7:0]                   command_index,
	input  logic [7:0]                   write_data,
	input  logic [7:0]                   status_value,
	input  logic [7:0]                   read_value,
	input  logic                         cfg_wr_en,
	input  logic [sbds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbds_pkg::TICK_W-1:0]  cfg_data,
	output logic                         job_push,
	output sbds_pkg::job_t               job
);
	import sbds_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_IDLE_WAIT, PH_CYCLE, PH_DATA} phase_t;

	phase_t            phase_q, phase_d;
	logic              is_read_q, is_read_d;
	logic [TICK_W-1:0] deadline_q, deadline_d;
	logic [6:0]        address_q, address_d;
	logic [7:0]        command_q, command_d;
	logic [7:0]        data_q, data_d;
	logic [TICK_W-1:0] idle_timeout_q;
	logic [TICK_W-1:0] cycle_timeout_q;
	logic              st_error;
	logic              deadline_zero;

	assign st_error = status_value[ST_ABORT_BIT] | status_value[ST_COLLIDE_BIT]
		| status_value[ST_PROTO_BIT] | status_value[ST_BUSTO_BIT];
	assign deadline_zero = (deadline_q == '0);

	always_comb begin
		phase_d = phase_q;
		is_read_d = is_read_q;
		deadline_d = deadline_q;
		address_d = address_q;
		command_d = command_q;
		data_d = data_q;
		job_push = 1'b0;
		job.kind = JOB_RD_STATUS;
		job.err = ERR_OK;
		job.rb = 8'd0;
		job.addr_byte = {address_q, is_read_q};
		job.command = command_q;
		job.data = data_q;
		job.is_read = is_read_q;
		if (accept) begin
			case (cmd)
				CMD_START_READ, CMD_START_WRITE: begin
					job_push = 1'b1;
					if (phase_q != PH_IDLE) begin
						job.kind = JOB_DONE;
						job.err = ERR_BUSY;
					end else begin
						is_read_d = (cmd == CMD_START_READ);
						address_d = target_address;
						command_d = command_index;
						data_d = write_data;
						deadline_d = idle_timeout_q;
						phase_d = PH_IDLE_WAIT;
						job.kind = JOB_RD_STATUS;
					end
				end
				CMD_STATUS: begin
					case (phase_q)
						PH_IDLE_WAIT: begin
							job_push = 1'b1;
							if (status_value[ST_BUSY_BIT]) begin
								if (deadline_zero) begin
									job.kind = JOB_DONE;
									job.err = ERR_BUSY;
									phase_d = PH_IDLE;
								end else begin
									job.kind = JOB_RD_STATUS;
								end
							end else begin
								job.kind = JOB_PROGRAM;
								deadline_d = cycle_timeout_q;
								phase_d = PH_CYCLE;
							end
						end
						PH_CYCLE: begin
							job_push = 1'b1;
							if (st_error) begin
								job.kind = JOB_CLEAR2_DONE;
								if (status_value[ST_COLLIDE_BIT]) begin
									job.err = ERR_IO;
								end else if (status_value[ST_ABORT_BIT]) begin
									job.err = ERR_CANCEL;
								end else if (status_value[ST_BUSTO_BIT]) begin
									job.err = ERR_TIME;
								end else begin
									job.err = ERR_IO;
								end
								phase_d = PH_IDLE;
							end else if (status_value[ST_DONE_BIT] && !status_value[ST_BUSY_BIT]) begin
								if (is_read_q) begin
									job.kind = JOB_RD_DATA;
									phase_d = PH_DATA;
								end else begin
									job.kind = JOB_CLEAR_DONE;
									phase_d = PH_IDLE;
								end
							end else if (deadline_zero) begin
								job.kind = JOB_CLEAR2_DONE;
								job.err = ERR_TIME;
								phase_d = PH_IDLE;
							end else begin
								job.kind = JOB_RD_STATUS;
							end
						end
						default: begin
						end
					endcase
				end
				CMD_DATA: begin
					if (phase_q == PH_DATA) begin
						job_push = 1'b1;
						job.kind = JOB_CLEAR_DONE;
						job.rb = read_value;
						phase_d = PH_IDLE;
					end
				end
				CMD_TICK: begin
					if ((phase_q == PH_IDLE_WAIT || phase_q == PH_CYCLE) && !deadline_zero) begin
						deadline_d = deadline_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			is_read_q <= 1'b0;
			deadline_q <= '0;
			address_q <= '0;
			command_q <= '0;
			data_q <= '0;
			idle_timeout_q <= IDLE_TIMEOUT_RESET;
			cycle_timeout_q <= CYCLE_TIMEOUT_RESET;
		end else begin
			phase_q <= phase_d;
			is_read_q <= is_read_d;
			deadline_q <= deadline_d;
			address_q <= address_d;
			command_q <= command_d;
			data_q <= data_d;
			if (cfg_wr_en && cfg_index == CFG_IDLE_TIMEOUT) begin
				idle_timeout_q <= cfg_data;
			end
			if (cfg_wr_en && cfg_index == CFG_CYCLE_TIMEOUT) begin
				cycle_timeout_q <= cfg_data;
			end
		end
	end

endmodule

/* hdl/sbds_queue.sv */
// Short job queue between the front end and the back end.
module sbds_queue #(
	parameter int DEPTH = sbds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbds_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output sbds_pkg::job_t head_job,
	output logic           q_empty
);
	import sbds_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !q_empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* hdl/sbds_back.sv */
// Back end: expands the job at the queue head into register accesses and completions.
`include "smbus_byte_data_sequencer_unit_defines.svh"
module sbds_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sbds_pkg::job_t head_job,
	input  logic           q_empty,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output sbds_pkg::result_t result
);
	import sbds_pkg::*;

	localparam logic [STEP_W-1:0] STEP_MAX = 3'd5;

	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q;
	result_t           res_q, res;
	logic              advance;

	always_comb begin
		res.kind = KIND_WR;
		res.offset = OFF_STATUS;
		res.data = ST_CLEAR_ALL;
		res.err = ERR_OK;
		res.rb = 8'd0;
		res.last = 1'b0;
		step_d = step_q + 1'b1;
		case (head_job.kind)
			JOB_RD_STATUS: begin
				res.kind = KIND_RD;
				res.data = 8'd0;
				res.last = 1'b1;
			end
			JOB_RD_DATA: begin
				res.kind = KIND_RD;
				res.offset = OFF_DATA;
				res.data = 8'd0;
				res.last = 1'b1;
			end
			JOB_DONE: begin
				res.kind = KIND_DONE;
				res.data = 8'd0;
				res.err = head_job.err;
				res.last = 1'b1;
			end
			JOB_PROGRAM: begin
				case (step_q)
					3'd0: begin
					end
					3'd1: begin
						res.offset = OFF_ADDRESS;
						res.data = head_job.addr_byte;
					end
					3'd2: begin
						res.offset = OFF_COMMAND;
						res.data = head_job.command;
						step_d = head_job.is_read ? 3'd4 : 3'd3;
					end
					3'd3: begin
						res.offset = OFF_DATA;
						res.data = head_job.data;
					end
					3'd4: begin
						res.offset = OFF_ENABLE;
						res.data = KICK_BYTE_DATA_START;
					end
					default: begin
						res.kind = KIND_RD;
						res.data = 8'd0;
						res.last = 1'b1;
					end
				endcase
			end
			JOB_CLEAR_DONE: begin
				if (step_q != 3'd0) begin
					res.kind = KIND_DONE;
					res.data = 8'd0;
					res.err = head_job.err;
					res.rb = head_job.rb;
					res.last = 1'b1;
				end
			end
			JOB_CLEAR2_DONE: begin
				if (step_q > 3'd1) begin
					res.kind = KIND_DONE;
					res.data = 8'd0;
					res.err = head_job.err;
					res.last = 1'b1;
				end
			end
			default: begin
				res.kind = KIND_DONE;
				res.data = 8'd0;
				res.err = ERR_IO;
				res.last = 1'b1;
			end
		endcase
	end

	assign advance = !q_empty && (!out_valid_q || pop);
	assign q_pop = advance && res.last;
	assign empty = !out_valid_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q <= res.last ? '0 : step_d;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	`SBDS_ASSERT_NOW(a_step_holds_job, step_q != '0, !q_empty, "job left the queue mid-sequence")
	`SBDS_ASSERT_NOW(a_step_range, 1'b1, step_q <= STEP_MAX, "sequence step out of range")
	`SBDS_ASSERT_NOW(a_done_is_last, out_valid_q && res_q.kind == KIND_DONE, res_q.last,
		"completion not marked last")
	`SBDS_ASSERT_NEXT(a_pop_on_last, advance && res.last, step_q == '0,
		"step not rewound after last result")

endmodule

/* hdl/smbus_byte_data_sequencer_unit.sv */
// Jobs pass through the job queue; results leave through the back end's output register.
// Throughput: one input item per cycle while the job queue has room; the back end emits
// one result per cycle while its output is empty or popped. A programming job writes status
// clear, address, command, data (writes only) and enable, then reads status. Reset: arst_n
// clears phase, queue pointers and output valid at once; timeouts return to 100000/50000 ticks.
module smbus_byte_data_sequencer_unit #(
	parameter int QUEUE_DEPTH = sbds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [2:0]                       cmd,
	input  logic [6:0]                       target_address,
	input  logic [7:0]                       command_index,
	input  logic [7:0]                       write_data,
	input  logic [7:0]                       status_value,
	input  logic [7:0]                       read_value,
	output logic                             empty,
	input  logic                             pop,
	output logic [1:0]                       result_kind,
	output logic [3:0]                       reg_offset,
	output logic [7:0]                       access_data,
	output logic [2:0]                       error_code,
	output logic [7:0]                       read_byte,
	output logic                             last,
	input  logic                             cfg_wr_en,
	input  logic [sbds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbds_pkg::TICK_W-1:0]      cfg_data
);
	import sbds_pkg::*;

	logic    accept;
	logic    job_push;
	job_t    job;
	job_t    head_job;
	logic    q_empty;
	logic    q_pop;
	result_t result;

	assign accept = push && !full;

	sbds_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(cmd),
		.target_address(target_address),
		.command_index(command_index),
		.write_data(write_data),
		.status_value(status_value),
		.read_value(read_value),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.job_push(job_push),
		.job(job)
	);

	sbds_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_job(job),
		.full(full),
		.pop(q_pop),
		.head_job(head_job),
		.q_empty(q_empty)
	);

	sbds_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_job(head_job),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	assign result_kind = result.kind;
	assign reg_offset = result.offset;
	assign access_data = result.data;
	assign error_code = result.err;
	assign read_byte = result.rb;
	assign last = result.last;

endmodule
